// ===== hdl/csp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package csp_pkg;

    localparam int MAX_NAME_LEN = 17;
    localparam int BUF_W        = 8 * MAX_NAME_LEN;

    localparam logic [4:0] LEN_MAX  = 5'd17;
    localparam logic [4:0] LEN_OVER = 5'd18;
    localparam logic [4:0] NOT_HEX  = 5'd16;
    localparam logic [7:0] HASH     = 8'h23;

    typedef enum logic [1:0] {
        KIND_RGB = 2'd0,
        KIND_PAL = 2'd1,
        KIND_BAD = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIN,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic [BUF_W-1:0] text;
        logic [7:0]       pal;
    } t_name_entry;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = NOT_HEX;
        if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61) + 5'd10;
        else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41) + 5'd10;
        return v;
    endfunction

    function automatic logic [7:0] group_first(input logic [4:0] len);
        logic [7:0] f;
        case (len)
            5'd4:    f = 8'd2;
            5'd5:    f = 8'd11;
            5'd6:    f = 8'd33;
            5'd7:    f = 8'd76;
            5'd8:    f = 8'd98;
            5'd9:    f = 8'd115;
            5'd10:   f = 8'd137;
            5'd11:   f = 8'd168;
            5'd12:   f = 8'd185;
            5'd13:   f = 8'd207;
            5'd14:   f = 8'd230;
            5'd15:   f = 8'd240;
            5'd17:   f = 8'd255;
            default: f = 8'd0;
        endcase
        return f;
    endfunction

    function automatic logic [5:0] group_size(input logic [4:0] len);
        logic [5:0] s;
        case (len)
            5'd3:    s = 6'd2;
            5'd4:    s = 6'd9;
            5'd5:    s = 6'd22;
            5'd6:    s = 6'd43;
            5'd7:    s = 6'd22;
            5'd8:    s = 6'd17;
            5'd9:    s = 6'd22;
            5'd10:   s = 6'd31;
            5'd11:   s = 6'd17;
            5'd12:   s = 6'd22;
            5'd13:   s = 6'd23;
            5'd14:   s = 6'd10;
            5'd15:   s = 6'd15;
            5'd17:   s = 6'd1;
            default: s = 6'd0;
        endcase
        return s;
    endfunction

    function automatic t_name_entry name_rom(input logic [7:0] idx);
        t_name_entry e;
        case (idx)
            8'd0:   e = '{"red", 8'd9};
            8'd1:   e = '{"tan", 8'd180};
            8'd2:   e = '{"navy", 8'd4};
            8'd3:   e = '{"teal", 8'd6};
            8'd4:   e = '{"grey", 8'd8};
            8'd5:   e = '{"lime", 8'd10};
            8'd6:   e = '{"blue", 8'd12};
            8'd7:   e = '{"aqua", 8'd14};
            8'd8:   e = '{"red3", 8'd124};
            8'd9:   e = '{"red3", 8'd160};
            8'd10:  e = '{"red1", 8'd196};
            8'd11:  e = '{"black", 8'd0};
            8'd12:  e = '{"green", 8'd2};
            8'd13:  e = '{"olive", 8'd3};
            8'd14:  e = '{"white", 8'd15};
            8'd15:  e = '{"grey0", 8'd16};
            8'd16:  e = '{"blue3", 8'd19};
            8'd17:  e = '{"blue3", 8'd20};
            8'd18:  e = '{"blue1", 8'd21};
            8'd19:  e = '{"cyan3", 8'd43};
            8'd20:  e = '{"cyan2", 8'd50};
            8'd21:  e = '{"cyan1", 8'd51};
            8'd22:  e = '{"plum4", 8'd96};
            8'd23:  e = '{"gold3", 8'd142};
            8'd24:  e = '{"pink3", 8'd175};
            8'd25:  e = '{"plum3", 8'd176};
            8'd26:  e = '{"gold3", 8'd178};
            8'd27:  e = '{"plum2", 8'd183};
            8'd28:  e = '{"pink1", 8'd218};
            8'd29:  e = '{"plum1", 8'd219};
            8'd30:  e = '{"gold1", 8'd220};
            8'd31:  e = '{"grey3", 8'd232};
            8'd32:  e = '{"grey7", 8'd233};
            8'd33:  e = '{"maroon", 8'd1};
            8'd34:  e = '{"purple", 8'd5};
            8'd35:  e = '{"silver", 8'd7};
            8'd36:  e = '{"yellow", 8'd11};
            8'd37:  e = '{"green4", 8'd28};
            8'd38:  e = '{"green3", 8'd34};
            8'd39:  e = '{"green3", 8'd40};
            8'd40:  e = '{"green1", 8'd46};
            8'd41:  e = '{"grey37", 8'd59};
            8'd42:  e = '{"purple", 8'd93};
            8'd43:  e = '{"wheat4", 8'd101};
            8'd44:  e = '{"grey53", 8'd102};
            8'd45:  e = '{"purple", 8'd129};
            8'd46:  e = '{"grey63", 8'd139};
            8'd47:  e = '{"grey69", 8'd145};
            8'd48:  e = '{"orchid", 8'd170};
            8'd49:  e = '{"violet", 8'd177};
            8'd50:  e = '{"khaki3", 8'd185};
            8'd51:  e = '{"grey84", 8'd188};
            8'd52:  e = '{"khaki1", 8'd228};
            8'd53:  e = '{"wheat1", 8'd229};
            8'd54:  e = '{"grey11", 8'd234};
            8'd55:  e = '{"grey15", 8'd235};
            8'd56:  e = '{"grey19", 8'd236};
            8'd57:  e = '{"grey23", 8'd237};
            8'd58:  e = '{"grey27", 8'd238};
            8'd59:  e = '{"grey30", 8'd239};
            8'd60:  e = '{"grey35", 8'd240};
            8'd61:  e = '{"grey39", 8'd241};
            8'd62:  e = '{"grey42", 8'd242};
            8'd63:  e = '{"grey46", 8'd243};
            8'd64:  e = '{"grey50", 8'd244};
            8'd65:  e = '{"grey54", 8'd245};
            8'd66:  e = '{"grey58", 8'd246};
            8'd67:  e = '{"grey62", 8'd247};
            8'd68:  e = '{"grey66", 8'd248};
            8'd69:  e = '{"grey70", 8'd249};
            8'd70:  e = '{"grey74", 8'd250};
            8'd71:  e = '{"grey78", 8'd251};
            8'd72:  e = '{"grey82", 8'd252};
            8'd73:  e = '{"grey85", 8'd253};
            8'd74:  e = '{"grey89", 8'd254};
            8'd75:  e = '{"grey93", 8'd255};
            8'd76:  e = '{"fuchsia", 8'd13};
            8'd77:  e = '{"darkred", 8'd52};
            8'd78:  e = '{"purple4", 8'd54};
            8'd79:  e = '{"purple4", 8'd55};
            8'd80:  e = '{"purple3", 8'd56};
            8'd81:  e = '{"orange4", 8'd58};
            8'd82:  e = '{"darkred", 8'd88};
            8'd83:  e = '{"orange4", 8'd94};
            8'd84:  e = '{"yellow4", 8'd100};
            8'd85:  e = '{"yellow4", 8'd106};
            8'd86:  e = '{"yellow3", 8'd148};
            8'd87:  e = '{"orange3", 8'd172};
            8'd88:  e = '{"yellow3", 8'd184};
            8'd89:  e = '{"yellow2", 8'd190};
            8'd90:  e = '{"hotpink", 8'd205};
            8'd91:  e = '{"hotpink", 8'd206};
            8'd92:  e = '{"salmon1", 8'd209};
            8'd93:  e = '{"orchid2", 8'd212};
            8'd94:  e = '{"orchid1", 8'd213};
            8'd95:  e = '{"orange1", 8'd214};
            8'd96:  e = '{"yellow1", 8'd226};
            8'd97:  e = '{"grey100", 8'd231};
            8'd98:  e = '{"navyblue", 8'd17};
            8'd99:  e = '{"darkblue", 8'd18};
            8'd100: e = '{"darkcyan", 8'd36};
            8'd101: e = '{"skyblue3", 8'd74};
            8'd102: e = '{"skyblue2", 8'd111};
            8'd103: e = '{"skyblue1", 8'd117};
            8'd104: e = '{"magenta3", 8'd127};
            8'd105: e = '{"hotpink3", 8'd132};
            8'd106: e = '{"magenta3", 8'd163};
            8'd107: e = '{"magenta3", 8'd164};
            8'd108: e = '{"magenta2", 8'd165};
            8'd109: e = '{"hotpink3", 8'd168};
            8'd110: e = '{"hotpink2", 8'd169};
            8'd111: e = '{"thistle3", 8'd182};
            8'd112: e = '{"magenta2", 8'd200};
            8'd113: e = '{"magenta1", 8'd201};
            8'd114: e = '{"thistle1", 8'd225};
            8'd115: e = '{"darkgreen", 8'd22};
            8'd116: e = '{"deeppink4", 8'd53};
            8'd117: e = '{"steelblue", 8'd67};
            8'd118: e = '{"cadetblue", 8'd72};
            8'd119: e = '{"cadetblue", 8'd73};
            8'd120: e = '{"seagreen3", 8'd78};
            8'd121: e = '{"seagreen2", 8'd83};
            8'd122: e = '{"seagreen1", 8'd84};
            8'd123: e = '{"seagreen1", 8'd85};
            8'd124: e = '{"deeppink4", 8'd89};
            8'd125: e = '{"deeppink4", 8'd125};
            8'd126: e = '{"indianred", 8'd131};
            8'd127: e = '{"rosybrown", 8'd138};
            8'd128: e = '{"darkkhaki", 8'd143};
            8'd129: e = '{"deeppink3", 8'd161};
            8'd130: e = '{"deeppink3", 8'd162};
            8'd131: e = '{"indianred", 8'd167};
            8'd132: e = '{"honeydew2", 8'd194};
            8'd133: e = '{"deeppink2", 8'd197};
            8'd134: e = '{"deeppink1", 8'd198};
            8'd135: e = '{"deeppink1", 8'd199};
            8'd136: e = '{"cornsilk1", 8'd230};
            8'd137: e = '{"turquoise4", 8'd30};
            8'd138: e = '{"turquoise2", 8'd45};
            8'd139: e = '{"blueviolet", 8'd57};
            8'd140: e = '{"slateblue3", 8'd61};
            8'd141: e = '{"slateblue3", 8'd62};
            8'd142: e = '{"royalblue1", 8'd63};
            8'd143: e = '{"steelblue3", 8'd68};
            8'd144: e = '{"steelblue1", 8'd75};
            8'd145: e = '{"palegreen3", 8'd77};
            8'd146: e = '{"steelblue1", 8'd81};
            8'd147: e = '{"darkviolet", 8'd92};
            8'd148: e = '{"lightpink4", 8'd95};
            8'd149: e = '{"slateblue1", 8'd99};
            8'd150: e = '{"palegreen3", 8'd114};
            8'd151: e = '{"lightgreen", 8'd119};
            8'd152: e = '{"lightgreen", 8'd120};
            8'd153: e = '{"palegreen1", 8'd121};
            8'd154: e = '{"darkviolet", 8'd128};
            8'd155: e = '{"lightcyan3", 8'd152};
            8'd156: e = '{"palegreen1", 8'd156};
            8'd157: e = '{"lightpink3", 8'd174};
            8'd158: e = '{"mistyrose3", 8'd181};
            8'd159: e = '{"lightcyan1", 8'd195};
            8'd160: e = '{"orangered1", 8'd202};
            8'd161: e = '{"indianred1", 8'd203};
            8'd162: e = '{"indianred1", 8'd204};
            8'd163: e = '{"darkorange", 8'd208};
            8'd164: e = '{"lightcoral", 8'd210};
            8'd165: e = '{"sandybrown", 8'd215};
            8'd166: e = '{"lightpink1", 8'd217};
            8'd167: e = '{"mistyrose1", 8'd224};
            8'd168: e = '{"dodgerblue3", 8'd26};
            8'd169: e = '{"dodgerblue2", 8'd27};
            8'd170: e = '{"dodgerblue1", 8'd33};
            8'd171: e = '{"chartreuse4", 8'd64};
            8'd172: e = '{"chartreuse3", 8'd70};
            8'd173: e = '{"chartreuse3", 8'd76};
            8'd174: e = '{"aquamarine3", 8'd79};
            8'd175: e = '{"chartreuse2", 8'd82};
            8'd176: e = '{"aquamarine1", 8'd86};
            8'd177: e = '{"darkmagenta", 8'd90};
            8'd178: e = '{"darkmagenta", 8'd91};
            8'd179: e = '{"chartreuse2", 8'd112};
            8'd180: e = '{"chartreuse1", 8'd118};
            8'd181: e = '{"aquamarine1", 8'd122};
            8'd182: e = '{"darkorange3", 8'd130};
            8'd183: e = '{"greenyellow", 8'd154};
            8'd184: e = '{"darkorange3", 8'd166};
            8'd185: e = '{"deepskyblue4", 8'd23};
            8'd186: e = '{"deepskyblue4", 8'd24};
            8'd187: e = '{"deepskyblue4", 8'd25};
            8'd188: e = '{"springgreen4", 8'd29};
            8'd189: e = '{"deepskyblue3", 8'd31};
            8'd190: e = '{"deepskyblue3", 8'd32};
            8'd191: e = '{"springgreen3", 8'd35};
            8'd192: e = '{"deepskyblue2", 8'd38};
            8'd193: e = '{"deepskyblue1", 8'd39};
            8'd194: e = '{"springgreen3", 8'd41};
            8'd195: e = '{"springgreen2", 8'd42};
            8'd196: e = '{"springgreen2", 8'd47};
            8'd197: e = '{"springgreen1", 8'd48};
            8'd198: e = '{"mediumpurple", 8'd104};
            8'd199: e = '{"darkseagreen", 8'd108};
            8'd200: e = '{"mediumorchid", 8'd134};
            8'd201: e = '{"lightsalmon3", 8'd137};
            8'd202: e = '{"navajowhite3", 8'd144};
            8'd203: e = '{"lightsalmon3", 8'd173};
            8'd204: e = '{"lightyellow3", 8'd187};
            8'd205: e = '{"lightsalmon1", 8'd216};
            8'd206: e = '{"navajowhite1", 8'd223};
            8'd207: e = '{"lightseagreen", 8'd37};
            8'd208: e = '{"darkturquoise", 8'd44};
            8'd209: e = '{"mediumpurple4", 8'd60};
            8'd210: e = '{"darkseagreen4", 8'd65};
            8'd211: e = '{"darkseagreen4", 8'd71};
            8'd212: e = '{"mediumpurple3", 8'd97};
            8'd213: e = '{"mediumpurple3", 8'd98};
            8'd214: e = '{"lightskyblue3", 8'd109};
            8'd215: e = '{"lightskyblue3", 8'd110};
            8'd216: e = '{"darkseagreen3", 8'd115};
            8'd217: e = '{"mediumorchid3", 8'd133};
            8'd218: e = '{"mediumpurple2", 8'd135};
            8'd219: e = '{"darkgoldenrod", 8'd136};
            8'd220: e = '{"mediumpurple2", 8'd140};
            8'd221: e = '{"mediumpurple1", 8'd141};
            8'd222: e = '{"darkseagreen3", 8'd150};
            8'd223: e = '{"darkseagreen2", 8'd151};
            8'd224: e = '{"lightskyblue1", 8'd153};
            8'd225: e = '{"darkseagreen2", 8'd157};
            8'd226: e = '{"darkseagreen1", 8'd158};
            8'd227: e = '{"mediumorchid1", 8'd171};
            8'd228: e = '{"darkseagreen1", 8'd193};
            8'd229: e = '{"mediumorchid1", 8'd207};
            8'd230: e = '{"paleturquoise4", 8'd66};
            8'd231: e = '{"cornflowerblue", 8'd69};
            8'd232: e = '{"darkslategray2", 8'd87};
            8'd233: e = '{"lightslategrey", 8'd103};
            8'd234: e = '{"lightslateblue", 8'd105};
            8'd235: e = '{"darkslategray3", 8'd116};
            8'd236: e = '{"darkslategray1", 8'd123};
            8'd237: e = '{"lightsteelblue", 8'd147};
            8'd238: e = '{"paleturquoise1", 8'd159};
            8'd239: e = '{"palevioletred1", 8'd211};
            8'd240: e = '{"mediumturquoise", 8'd80};
            8'd241: e = '{"darkolivegreen3", 8'd107};
            8'd242: e = '{"darkolivegreen3", 8'd113};
            8'd243: e = '{"mediumvioletred", 8'd126};
            8'd244: e = '{"lightsteelblue3", 8'd146};
            8'd245: e = '{"darkolivegreen3", 8'd149};
            8'd246: e = '{"darkolivegreen2", 8'd155};
            8'd247: e = '{"lightgoldenrod3", 8'd179};
            8'd248: e = '{"lightgoldenrod2", 8'd186};
            8'd249: e = '{"lightsteelblue1", 8'd189};
            8'd250: e = '{"darkolivegreen1", 8'd191};
            8'd251: e = '{"darkolivegreen1", 8'd192};
            8'd252: e = '{"lightgoldenrod2", 8'd221};
            8'd253: e = '{"lightgoldenrod2", 8'd222};
            8'd254: e = '{"lightgoldenrod1", 8'd227};
            default: e = '{"mediumspringgreen", 8'd49};
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/color_string_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake           Payload
// input     i_valid / o_ready   i_char_code, i_last_char, i_empty_string
// output    o_valid / i_ready   o_color_kind, o_red, o_green, o_blue
//
// Characters are taken one per cycle while the parser is idle and the output is free. A final
// character starts a decode, and a name then scans ROM entries one by one (up to 43, the largest length group).
// A single compare unit scans the name ROM against the character buffer.
// Reset clears the sequencer, the character count and the output valid.
// A result waiting at the output holds back the input channel.

module color_string_parser (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire  [7:0]           i_char_code,
    input  wire                  i_last_char,
    input  wire                  i_empty_string,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic [1:0]           o_color_kind,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue
);
    import csp_pkg::*;

    t_state           r_state, n_state;
    logic [4:0]       r_count, n_count;
    logic [BUF_W-1:0] r_buf;
    logic [7:0]       r_idx;
    logic [5:0]       r_left;
    logic             r_out_valid;
    t_kind            r_kind;
    logic [7:0]       r_red, r_green, r_blue;

    logic        out_free, accept;
    logic [7:0]  first_byte;
    logic [4:0]  d [6];
    logic        len_bad, is_hash, hex_ok, to_scan, hit;
    logic [5:0]  grp_size;
    logic [7:0]  hx_r, hx_g, hx_b;
    t_name_entry rom_e;
    logic        wr_out;
    t_kind       wr_kind;
    logic [7:0]  wr_r, wr_g, wr_b;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == ST_IDLE) && out_free;
    assign accept   = i_valid && o_ready;

    always_comb begin
        first_byte = '0;
        for (int k = 0; k < MAX_NAME_LEN; k++) begin
            if (5'(k + 1) == r_count) begin
                first_byte = r_buf[k*8 +: 8];
            end
        end
        for (int k = 0; k < 6; k++) begin
            d[k] = hex_val(r_buf[k*8 +: 8]);
        end
    end

    assign len_bad  = (r_count == 5'd0) || (r_count > LEN_MAX);
    assign is_hash  = (first_byte == HASH);
    assign grp_size = group_size(r_count);
    assign to_scan  = !len_bad && !is_hash && (grp_size != 6'd0);
    assign rom_e    = name_rom(r_idx);
    assign hit      = (rom_e.text == r_buf);

    always_comb begin
        hex_ok = 1'b0;
        hx_r   = '0;
        hx_g   = '0;
        hx_b   = '0;
        unique case (r_count)
            5'd7: begin
                hex_ok = (d[0] != NOT_HEX) && (d[1] != NOT_HEX) && (d[2] != NOT_HEX)
                      && (d[3] != NOT_HEX) && (d[4] != NOT_HEX) && (d[5] != NOT_HEX);
                hx_r = {d[5][3:0], d[4][3:0]};
                hx_g = {d[3][3:0], d[2][3:0]};
                hx_b = {d[1][3:0], d[0][3:0]};
            end
            5'd4: begin
                hex_ok = (d[0] != NOT_HEX) && (d[1] != NOT_HEX) && (d[2] != NOT_HEX);
                hx_r = {d[2][3:0], d[2][3:0]};
                hx_g = {d[1][3:0], d[1][3:0]};
                hx_b = {d[0][3:0], d[0][3:0]};
            end
            5'd2: begin
                hex_ok = (d[0] != NOT_HEX);
                hx_r = {d[0][3:0], d[0][3:0]};
                hx_g = hx_r;
                hx_b = hx_r;
            end
            default: begin
                hex_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && !i_empty_string && i_last_char) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (to_scan) begin
                    n_state = ST_SCAN;
                end else if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if ((hit || r_left == 6'd1) && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        wr_out  = 1'b0;
        wr_kind = KIND_BAD;
        wr_r    = '0;
        wr_g    = '0;
        wr_b    = '0;
        n_count = r_count;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_empty_string) begin
                        wr_out  = 1'b1;
                        n_count = '0;
                    end else if (r_count <= LEN_MAX) begin
                        n_count = r_count + 5'd1;
                    end
                end
            end
            ST_FIN: begin
                if (!to_scan && out_free) begin
                    wr_out  = 1'b1;
                    n_count = '0;
                    if (!len_bad && is_hash && hex_ok) begin
                        wr_kind = KIND_RGB;
                        wr_r    = hx_r;
                        wr_g    = hx_g;
                        wr_b    = hx_b;
                    end
                end
            end
            ST_SCAN: begin
                if ((hit || r_left == 6'd1) && out_free) begin
                    wr_out  = 1'b1;
                    n_count = '0;
                    if (hit) begin
                        wr_kind = KIND_PAL;
                        wr_r    = rom_e.pal;
                    end
                end
            end
            default: begin
                wr_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (wr_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !i_empty_string) begin
            if (r_count == 5'd0) begin
                r_buf <= {{(BUF_W-8){1'b0}}, i_char_code};
            end else if (r_count < LEN_MAX) begin
                r_buf <= {r_buf[BUF_W-9:0], i_char_code};
            end
        end
        if (r_state == ST_FIN) begin
            r_idx  <= group_first(r_count);
            r_left <= grp_size;
        end else if (r_state == ST_SCAN && !hit && r_left != 6'd1) begin
            r_idx  <= r_idx + 8'd1;
            r_left <= r_left - 6'd1;
        end
        if (wr_out) begin
            r_kind  <= wr_kind;
            r_red   <= wr_r;
            r_green <= wr_g;
            r_blue  <= wr_b;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_color_kind = r_kind;
    assign o_red        = r_red;
    assign o_green      = r_green;
    assign o_blue       = r_blue;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LEN_OVER) else $error("character count out of range");
    a_scan_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_left != 6'd0)) else $error("scan with no entries left");
    a_empty_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_empty_string) |=> (r_count == 5'd0 && r_out_valid))
        else $error("empty string not finished");
    a_fin_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_empty_string && i_last_char) |=> (r_state == ST_FIN))
        else $error("last character did not start decode");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import csp_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_char_code = 8'd0;
    logic       i_last_char = 1'b0;
    logic       i_empty_string = 1'b0;
    logic       i_ready = 1'b0;
    logic       o_ready, o_valid;
    logic [1:0] o_color_kind;
    logic [7:0] o_red, o_green, o_blue;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_color;

    t_color     color_q[$];
    logic [7:0] str_buf[MAX_NAME_LEN];
    int         str_len = 0;
    int         errors = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_off = 0;

    string names[] = '{
        "red", "tan", "navy", "teal", "grey", "lime", "blue", "aqua", "red3", "red1",
        "black", "green", "olive", "white", "grey0", "blue3", "cyan1", "plum4", "gold3",
        "grey7", "maroon", "purple", "silver", "yellow", "green3", "grey93", "orchid",
        "wheat1", "grey100", "fuchsia", "darkred", "purple4", "hotpink", "navyblue",
        "magenta3", "thistle1", "darkgreen", "deeppink4", "cornsilk1", "turquoise4",
        "lightgreen", "mistyrose1", "dodgerblue3", "darkorange3", "deepskyblue4",
        "navajowhite1", "lightseagreen", "mediumorchid1", "paleturquoise4",
        "palevioletred1", "mediumturquoise", "lightgoldenrod1", "mediumspringgreen"
    };

    // Name table for prediction, kept as strings and built from the package name ROM.
    string      rom_txt[256];
    logic [7:0] rom_pal[256];

    color_string_parser dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic int nib(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic t_color decode_string(input int len);
        t_color res;
        int     d[6];
        int     n;
        string  s;
        res = '{KIND_BAD, 8'd0, 8'd0, 8'd0};
        if (len == 0 || len > MAX_NAME_LEN) return res;
        if (str_buf[0] == HASH) begin
            n = (len == 7) ? 6 : (len == 4) ? 3 : (len == 2) ? 1 : 0;
            if (n == 0) return res;
            for (int k = 0; k < n; k++) begin
                d[k] = nib(str_buf[k + 1]);
                if (d[k] < 0) return res;
            end
            if (n == 6) res = '{KIND_RGB, 8'(d[0] * 16 + d[1]), 8'(d[2] * 16 + d[3]),
                                8'(d[4] * 16 + d[5])};
            else if (n == 3) res = '{KIND_RGB, 8'(d[0] * 17), 8'(d[1] * 17), 8'(d[2] * 17)};
            else res = '{KIND_RGB, 8'(d[0] * 17), 8'(d[0] * 17), 8'(d[0] * 17)};
            return res;
        end
        s = "";
        for (int k = 0; k < len; k++) s = {s, string'(str_buf[k])};
        if (s.len() != len) return res;
        for (int e = 0; e < 256; e++) begin
            if (rom_txt[e] == s) begin
                res = '{KIND_PAL, rom_pal[e], 8'd0, 8'd0};
                return res;
            end
        end
        return res;
    endfunction

    function automatic void predict_char(input logic [7:0] c, input logic lst, input logic emp);
        if (emp) begin
            str_len = 0;
            color_q.push_back('{KIND_BAD, 8'd0, 8'd0, 8'd0});
            return;
        end
        if (str_len < MAX_NAME_LEN) str_buf[str_len] = c;
        if (str_len <= MAX_NAME_LEN) str_len++;
        if (lst) begin
            color_q.push_back(decode_string(str_len));
            str_len = 0;
        end
    endfunction

    task automatic send_char(input logic [7:0] c, input logic lst, input logic emp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_char_code <= c;
        i_last_char <= lst;
        i_empty_string <= emp;
        predict_char(c, lst, emp);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_char(s[k], k == s.len() - 1, 1'b0);
    endtask

    function automatic string hex_text(input int n);
        string s;
        string digs;
        digs = "0123456789abcdefABCDEF";
        s = "#";
        for (int k = 0; k < n; k++) s = {s, string'(digs[$urandom_range(21)])};
        return s;
    endfunction

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (color_q.size() == 0) begin
                $display("%0t unexpected result kind=%0d r=%0d g=%0d b=%0d", $time,
                         o_color_kind, o_red, o_green, o_blue);
                errors++;
            end else begin
                if (color_q[0] != {o_color_kind, o_red, o_green, o_blue}) begin
                    $display("%0t mismatch: expected %h actual %h", $time, color_q[0],
                             {o_color_kind, o_red, o_green, o_blue});
                    errors++;
                end
                void'(color_q.pop_front());
            end
        end
    end

    task automatic test_directed();
        send_text("#000000");
        send_text("#FFFFFF");
        send_text("#a1B2c3");
        send_text("#fA0");
        send_text("#7");
        send_text("#");
        send_text("#12345");
        send_text("#12g456");
        send_text("#:9");
        send_text("red");
        send_text("red3");
        send_text("gold3");
        send_text("purple");
        send_text("mediumspringgreen");
        send_text("Red");
        send_text("grey0x");
        send_text("abcdefghijklmnopqrstu");
        send_text("abcdefghijklmnopq");
        send_char(8'h00, 1'b0, 1'b1);
        send_char("x", 1'b0, 1'b0);
        send_char(8'hff, 1'b1, 1'b1);
        send_char(8'hff, 1'b1, 1'b0);
        send_char(8'h80, 1'b1, 1'b0);
    endtask

    task automatic test_random(input int n_items);
        int    cnt;
        int    pick;
        string s;
        cnt = 0;
        while (cnt < n_items) begin
            pick = $urandom_range(9);
            if (pick < 3) s = names[$urandom_range(names.size() - 1)];
            else if (pick < 6) s = hex_text($urandom_range(2) == 0 ? 1 :
                                             $urandom_range(1) ? 3 : 6);
            else if (pick == 6) s = hex_text($urandom_range(8));
            else s = "";
            if (pick == 7) begin
                send_char(8'($urandom), 1'($urandom), 1'b1);
                cnt++;
            end else if (pick >= 8) begin
                for (int k = $urandom_range(21); k >= 0; k--) begin
                    send_char(8'($urandom), k == 0, 1'b0);
                    cnt++;
                end
            end else begin
                if ($urandom_range(19) == 0 && s.len() > 1) s[$urandom_range(s.len() - 1)] =
                    8'($urandom);
                send_text(s);
                cnt += s.len();
            end
        end
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        for (int k = 0; k < 12; k++) send_text("red");
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (color_q.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
    endtask

    initial begin
        foreach (rom_txt[e]) rom_txt[e] = "";
        for (int e = 0; e < 256; e++) begin
            t_name_entry ent;
            string       s;
            ent = name_rom(8'(e));
            s = "";
            for (int k = MAX_NAME_LEN - 1; k >= 0; k--)
                if (ent.text[k*8 +: 8] != 8'd0) s = {s, string'(ent.text[k*8 +: 8])};
            rom_txt[e] = s;
            rom_pal[e] = ent.pal;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(120);
        send_idle_pct = 77;
        test_random(120);
        send_idle_pct = 0;
        recv_stall_pct = 77;
        test_random(120);
        send_idle_pct = 25;
        recv_stall_pct = 25;
        test_random(120);
        drain();
        if (errors == 0 && color_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            if (color_q.size() != 0) $display("%0d results never arrived", color_q.size());
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/csp_pkg.sv
hdl/color_string_parser.sv
dv/tb.sv
